// ----- design/esort_pkg.sv -----
package esort_pkg;

    // field widths of one entry
    localparam int KEY_W = 10;
    localparam int TAG_W = 7;

    // one stored entry: key with its row and column payload
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] row;
        logic [TAG_W-1:0] col;
    } t_entry;

    // controller commands to the datapath
    typedef struct packed {
        logic load;       // write the input transfer at the write address
        logic store;      // write the held entry back at the write address
        logic rd_cur;     // read at the read address into the held entry
        logic rd_cmp;     // read at the read address and compare with the held entry
        logic emit;       // read at the read address into the output register
        logic emit_last;  // the emitted entry closes the run
    } t_cmd;

    // datapath status to the controller
    typedef struct packed {
        logic out_free;   // output register can take a new entry this cycle
    } t_status;

endpackage

// ----- design/esort_ctrl.sv -----
module esort_ctrl #(
    parameter int ENTRIES = 64,
    parameter int IW      = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  esort_pkg::t_status i_status,
    output esort_pkg::t_cmd   o_cmd,
    output logic [IW-1:0]     o_rd_addr,
    output logic [IW-1:0]     o_wr_addr
);
    import esort_pkg::*;

    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_FETCH = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_STORE = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_j, n_j;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_j       = r_j;
        o_cmd     = '0;
        o_rd_addr = '0;
        o_wr_addr = '0;
        o_stall   = 1'b1;
        case (r_state)
            S_LOAD: begin
                o_stall   = 1'b0;
                o_wr_addr = r_cnt;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (r_cnt == LAST) begin
                        n_cnt   = '0;
                        n_i     = '0;
                        n_state = S_FETCH;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.rd_cur = 1'b1;
                o_rd_addr    = r_i;
                n_j          = r_i + 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.rd_cmp = 1'b1;
                o_rd_addr    = r_j;
                if (r_j == LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DRAIN: begin
                // last compare of the scan resolves this cycle
                n_state = S_STORE;
            end
            S_STORE: begin
                // write back position i, and fetch position i+1 on the same cycle unless i is LAST-1
                o_cmd.store = 1'b1;
                o_wr_addr   = r_i;
                if (r_i == LAST - 1'b1) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    o_rd_addr    = r_i + 1'b1;
                    n_i          = r_i + 1'b1;
                    n_j          = r_i + 1'b1 + 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_EMIT: begin
                o_rd_addr = r_cnt;
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = (r_cnt == LAST);
                    if (r_cnt == LAST) begin
                        n_cnt   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
                n_cnt   = '0;
            end
        endcase
    end

endmodule

// ----- design/esort_dp.sv -----
module esort_dp #(
    parameter int ENTRIES = 64,
    parameter int IW      = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  esort_pkg::t_cmd              i_cmd,
    input  logic [IW-1:0]                i_rd_addr,
    input  logic [IW-1:0]                i_wr_addr,
    input  logic [esort_pkg::KEY_W-1:0]  i_sort_key,
    input  logic [esort_pkg::TAG_W-1:0]  i_row_tag,
    input  logic [esort_pkg::TAG_W-1:0]  i_col_tag,
    input  logic                         i_stall,
    output esort_pkg::t_status           o_status,
    output logic                         o_valid,
    output logic [esort_pkg::KEY_W-1:0]  o_out_key,
    output logic [esort_pkg::TAG_W-1:0]  o_out_row,
    output logic [esort_pkg::TAG_W-1:0]  o_out_col,
    output logic                         o_final_entry
);
    import esort_pkg::*;

    t_entry        r_mem [ENTRIES];
    t_entry        r_rd;
    t_entry        r_cur;
    t_entry        r_out;
    logic          r_out_vld;
    logic          r_out_last;
    logic          r_tag_cur;
    logic          r_tag_cmp;
    logic [IW-1:0] r_tag_addr;
    t_entry        in_entry;
    logic          swap;

    assign in_entry = '{key: i_sort_key, row: i_row_tag, col: i_col_tag};

    // scanned entry beats the held one: exchange them
    assign swap = r_tag_cmp && (r_rd.key < r_cur.key);

    // entry store, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[i_wr_addr] <= in_entry;
        end else if (i_cmd.store) begin
            r_mem[i_wr_addr] <= r_cur;
        end else if (swap) begin
            r_mem[r_tag_addr] <= r_cur;
        end
    end

    // one read port feeding the sort and the output register
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_addr];
        if (i_cmd.emit) begin
            r_out      <= r_mem[i_rd_addr];
            r_out_last <= i_cmd.emit_last;
        end
    end

    // read tags are registered alongside the read data, so they line up with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_cur <= 1'b0;
            r_tag_cmp <= 1'b0;
        end else begin
            r_tag_cur <= i_cmd.rd_cur;
            r_tag_cmp <= i_cmd.rd_cmp;
        end
        r_tag_addr <= i_rd_addr;
    end

    // held entry for the current sorted position
    always_ff @(posedge i_clk) begin
        if (r_tag_cur || swap) begin
            r_cur <= r_rd;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_vld || !i_stall;
    assign o_valid           = r_out_vld;
    assign o_out_key         = r_out.key;
    assign o_out_row         = r_out.row;
    assign o_out_col         = r_out.col;
    assign o_final_entry     = r_out_last;

endmodule

// ----- design/exchange_sort_key_payload.sv -----
// channel | handshake          | payload
// input   | i_valid / o_stall  | i_sort_key[9:0], i_row_tag[6:0], i_col_tag[6:0]
// output  | o_valid / i_stall  | o_out_key[9:0], o_out_row[6:0], o_out_col[6:0], o_final_entry
//
// loading takes one cycle per transfer; after the last of ENTRIES transfers the
// sort runs on one comparator and one memory port, fetching each position's
// entry and scanning all later ones, swapping in any smaller key, then storing it.
// emission then gives one entry per cycle unless the output is stalled; input
// stays stalled through sort and emission, and the next run loads while the last
// entry waits. reset clears control only, no store sweep.
module exchange_sort_key_payload #(
    parameter int ENTRIES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [esort_pkg::KEY_W-1:0]  i_sort_key,
    input  logic [esort_pkg::TAG_W-1:0]  i_row_tag,
    input  logic [esort_pkg::TAG_W-1:0]  i_col_tag,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [esort_pkg::KEY_W-1:0]  o_out_key,
    output logic [esort_pkg::TAG_W-1:0]  o_out_row,
    output logic [esort_pkg::TAG_W-1:0]  o_out_col,
    output logic                         o_final_entry
);
    import esort_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    t_cmd          cmd;
    t_status       status;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;

    // sequencer
    esort_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_rd_addr (rd_addr),
        .o_wr_addr (wr_addr)
    );

    // store, comparator and output register
    esort_dp #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (wr_addr),
        .i_sort_key    (i_sort_key),
        .i_row_tag     (i_row_tag),
        .i_col_tag     (i_col_tag),
        .i_stall       (i_stall),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_out_key     (o_out_key),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_final_entry (o_final_entry)
    );

endmodule
